### rtl/core/ssl_pkg.sv
// Shared types, constants and helpers for the servo slew limiter.
package ssl_pkg;

  localparam int MAX_MOTORS   = 6;
  localparam int NUM_SERVOS_D = 6;
  localparam int ANG_W        = 9;
  localparam int PULSE_W      = 12;
  localparam int LIM_W        = 60;
  localparam int STEP_W       = 8;
  localparam int MOTOR_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  localparam logic [LIM_W-1:0]  LIMITS_RESET = 60'd703721825674291200;
  localparam logic [STEP_W-1:0] STEP_RESET   = 8'd1;

  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_PLACE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd0;

  // divider sizes: |2*num + span| and 2*span
  localparam int DVD_W = 25;
  localparam int DVS_W = 11;

  typedef struct packed {
    logic [MOTOR_W-1:0] motor;
    logic [PULSE_W-1:0] pulse;
    logic               cmd;
    logic               settled;
  } res_t;

  function automatic logic signed [ANG_W-1:0] clamp_ang(
      input logic signed [ANG_W-1:0] a, input logic [LIM_W-1:0] lw);
    logic signed [ANG_W-1:0] lo, hi, r;
    lo = lw[8:0];
    hi = lw[17:9];
    r  = a;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

### rtl/core/ssl_div.sv
// Restoring serial divider, one quotient bit per cycle.
module ssl_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ssl_pkg::DVD_W-1:0]   dividend,
  input  logic [ssl_pkg::DVS_W-1:0]   divisor,
  output logic                        done,
  output logic [ssl_pkg::DVD_W-1:0]   quo,
  output logic                        rem_nz
);
  localparam int CW = $clog2(ssl_pkg::DVD_W + 1);

  logic                       busy_r;
  logic [CW-1:0]              cnt_r;
  logic [ssl_pkg::DVD_W-1:0]  quo_r;
  logic [ssl_pkg::DVS_W-1:0]  rem_r, dvs_r;
  logic                       done_r;
  logic [ssl_pkg::DVS_W:0]    trial;
  logic [ssl_pkg::DVS_W:0]    shifted;

  assign shifted = {rem_r, quo_r[ssl_pkg::DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ssl_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (!trial[ssl_pkg::DVS_W]) begin
        rem_r <= trial[ssl_pkg::DVS_W-1:0];
        quo_r <= {quo_r[ssl_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[ssl_pkg::DVS_W-1:0];
        quo_r <= {quo_r[ssl_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done   = done_r;
  assign quo    = quo_r;
  assign rem_nz = (rem_r != '0);
endmodule

### rtl/core/ssl_pulse.sv
// Angle to pulse mapper: clamp, multiply, rounded floor divide, saturate.
module ssl_pulse (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ssl_pkg::ANG_W-1:0]   angle,
  input  logic [ssl_pkg::LIM_W-1:0]          limits,
  output logic                               done,
  output logic [ssl_pkg::PULSE_W-1:0]        pulse
);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_DIV  = 2'd2;

  logic [1:0]                  st_r;
  logic signed [9:0]           span_r, da_r;
  logic signed [12:0]          dp_r;
  logic [11:0]                 pmin_r;
  logic signed [22:0]          prod;
  logic signed [24:0]          num;
  logic                        neg_r;
  logic [ssl_pkg::DVD_W-1:0]   dvd;
  logic [ssl_pkg::DVS_W-1:0]   dvs;
  logic                        div_start, div_done, rem_nz;
  logic [ssl_pkg::DVD_W-1:0]   quo;
  logic signed [25:0]          q;
  logic signed [26:0]          p;
  logic                        done_r;
  logic [ssl_pkg::PULSE_W-1:0] pulse_r;
  logic signed [ssl_pkg::ANG_W-1:0] a;
  logic signed [9:0]           span_abs;

  assign a = ssl_pkg::clamp_ang(angle, limits);

  // product is formed from registered operands
  assign prod     = dp_r * da_r;
  assign span_abs = span_r[9] ? -span_r : span_r;
  always_comb begin
    if (span_r[9]) num = 25'(-(26'(prod) <<< 1)) + 25'(span_abs);
    else           num = (25'(prod) <<< 1) + 25'(span_abs);
  end
  assign dvd       = num[24] ? ssl_pkg::DVD_W'(-num) : ssl_pkg::DVD_W'(num);
  assign dvs       = ssl_pkg::DVS_W'({span_abs, 1'b0});
  assign div_start = (st_r == P_MUL) && (span_r != '0);

  ssl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quo(quo), .rem_nz(rem_nz)
  );

  always_comb begin
    if (neg_r) q = -($signed({1'b0, quo}) + 26'(rem_nz));
    else       q = $signed({1'b0, quo});
  end
  assign p = 27'($signed({1'b0, pmin_r})) + 27'(q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        P_IDLE: if (start) st_r <= P_MUL;
        P_MUL: begin
          if (span_r == '0) begin
            done_r <= 1'b1;
            st_r   <= P_IDLE;
          end else begin
            st_r <= P_DIV;
          end
        end
        P_DIV: begin
          if (div_done) begin
            done_r <= 1'b1;
            st_r   <= P_IDLE;
          end
        end
        default: st_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && st_r == P_IDLE) begin
      span_r <= 10'($signed(limits[35:27])) - 10'($signed(limits[26:18]));
      da_r   <= 10'(a) - 10'($signed(limits[26:18]));
      dp_r   <= $signed({1'b0, limits[59:48]}) - $signed({1'b0, limits[47:36]});
      pmin_r <= limits[47:36];
    end
    if (st_r == P_MUL) begin
      neg_r <= num[24];
      if (span_r == '0) pulse_r <= pmin_r;
    end
    if (st_r == P_DIV && div_done) begin
      if (p < 0)             pulse_r <= '0;
      else if (p > 27'sd4095) pulse_r <= 12'd4095;
      else                   pulse_r <= p[11:0];
    end
  end

  assign done  = done_r;
  assign pulse = pulse_r;
endmodule

### rtl/core/servo_slew_limiter_pulse_mapper_core.sv
// Servo slew limiter and pulse mapper: angle memories, tick sequencer, result register.
// Keeps target and current angles for NUM_SERVOS servos in two small synchronous
// memories. A set word gives no result. A place word gives one result. A tick
// visits every motor in turn: a memory read and a step, and for each motor that
// moves a pass through the serial divider in the pulse mapper. New words are taken
// only between items; a finished result waits in the output register while the
// next word is taken. Configuration writes are accepted every cycle.
module servo_slew_limiter_pulse_mapper_core #(
  parameter int NUM_SERVOS = ssl_pkg::NUM_SERVOS_D
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_mode,
  input  logic [ssl_pkg::MOTOR_W-1:0]           in_motor,
  input  logic signed [ssl_pkg::ANG_W-1:0]      in_angle,
  input  logic                                  in_emergency_stop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ssl_pkg::MOTOR_W-1:0]           out_motor,
  output logic [ssl_pkg::PULSE_W-1:0]           out_pulse_us,
  output logic                                  out_command_valid,
  output logic                                  out_all_settled,
  output logic                                  out_last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]        cfg_data
);
  localparam int AW = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_PWAIT = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                     st_r;
  logic [ssl_pkg::STEP_W-1:0]     step_r;
  logic [ssl_pkg::LIM_W-1:0]      lim_r [ssl_pkg::MAX_MOTORS];
  logic signed [ssl_pkg::ANG_W-1:0] tgt_mem [NUM_SERVOS];
  logic signed [ssl_pkg::ANG_W-1:0] cur_mem [NUM_SERVOS];
  logic [NUM_SERVOS-1:0]          tv_r, cv_r;
  logic signed [ssl_pkg::ANG_W-1:0] tgt_q, cur_q;
  logic                           tv_q, cv_q;
  logic [AW-1:0]                  m_r;
  logic [ssl_pkg::MOTOR_W-1:0]    mot_r;
  logic                           place_r, estop_r;
  ssl_pkg::res_t                  pend_r, new_r, out_r;
  logic                           pend_v_r, out_v_r, out_last_r;
  logic                           out_free, accept, in_ok;
  logic                           p_start, p_go_r, p_done;
  logic                           calc_mv, out_load;
  logic signed [ssl_pkg::ANG_W-1:0] p_angle_r;
  logic [ssl_pkg::PULSE_W-1:0]    p_pulse;
  logic [ssl_pkg::LIM_W-1:0]      lim_sel;
  logic signed [ssl_pkg::ANG_W-1:0] cur, tgt, nxt_ang;
  logic signed [9:0]              diff, stp;
  logic                           last_m;

  assign in_ready  = (st_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_ok     = (4'(in_motor) < 4'(NUM_SERVOS));
  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || out_ready;
  assign last_m    = (32'(m_r) == NUM_SERVOS - 1);
  assign lim_sel   = lim_r[mot_r];
  assign calc_mv   = (st_r == S_CALC) && !place_r && (diff != '0);
  assign out_load  = ((st_r == S_FLUSH) && pend_v_r && out_free) ||
                     ((st_r == S_FIN) && out_free);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ssl_pkg::STEP_RESET;
      for (int i = 0; i < ssl_pkg::MAX_MOTORS; i++) lim_r[i] <= ssl_pkg::LIMITS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == ssl_pkg::REG_STEP) step_r <= cfg_data[ssl_pkg::STEP_W-1:0];
      else if (cfg_index <= ssl_pkg::CFG_IDX_W'(ssl_pkg::MAX_MOTORS))
        lim_r[cfg_index - 1'b1] <= cfg_data[ssl_pkg::LIM_W-1:0];
    end
  end

  // step math on the registered memory read
  assign cur  = cv_q ? cur_q : '0;
  assign tgt  = ssl_pkg::clamp_ang(tv_q ? tgt_q : '0, lim_sel);
  assign diff = 10'(tgt) - 10'(cur);
  assign stp  = (step_r == '0) ? 10'sd1 : $signed({2'b00, step_r});
  always_comb begin
    if (diff > stp)       nxt_ang = ssl_pkg::ANG_W'(10'(cur) + stp);
    else if (diff < -stp) nxt_ang = ssl_pkg::ANG_W'(10'(cur) - stp);
    else                  nxt_ang = tgt;
  end

  // angle memories
  always_ff @(posedge clk) begin
    if (accept && in_ok && (in_mode == ssl_pkg::MODE_SET || in_mode == ssl_pkg::MODE_PLACE))
      tgt_mem[in_motor[AW-1:0]] <= in_angle;
    if (accept && in_ok && in_mode == ssl_pkg::MODE_PLACE)
      cur_mem[in_motor[AW-1:0]] <= in_angle;
    else if (calc_mv)
      cur_mem[m_r] <= nxt_ang;
    if (st_r == S_READ) begin
      tgt_q <= tgt_mem[m_r];
      cur_q <= cur_mem[m_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
      cv_r <= '0;
    end else begin
      if (accept && in_ok && (in_mode == ssl_pkg::MODE_SET || in_mode == ssl_pkg::MODE_PLACE))
        tv_r[in_motor[AW-1:0]] <= 1'b1;
      if (accept && in_ok && in_mode == ssl_pkg::MODE_PLACE)
        cv_r[in_motor[AW-1:0]] <= 1'b1;
      else if (calc_mv)
        cv_r[m_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_READ) begin
      tv_q <= tv_r[m_r];
      cv_q <= cv_r[m_r];
    end
  end

  assign p_start = (accept && in_ok && in_mode == ssl_pkg::MODE_PLACE) || calc_mv;

  // start is registered before it reaches the pulse unit, once angle and motor are registered
  always_ff @(posedge clk) begin
    if (!rst_n) p_go_r <= 1'b0;
    else        p_go_r <= p_start;
  end

  ssl_pulse u_pulse (
    .clk(clk), .rst_n(rst_n), .start(p_go_r), .angle(p_angle_r),
    .limits(lim_sel), .done(p_done), .pulse(p_pulse)
  );

  always_ff @(posedge clk) begin
    if (accept) p_angle_r <= in_angle;
    else if (calc_mv) p_angle_r <= nxt_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_v_r <= 1'b0;
    else if (out_load) out_v_r <= 1'b1;
    else if (out_ready) out_v_r <= 1'b0;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pend_v_r <= 1'b0;
      m_r      <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (accept) begin
            estop_r <= in_emergency_stop;
            m_r     <= '0;
            if (in_mode == ssl_pkg::MODE_TICK) begin
              place_r <= 1'b0;
              mot_r   <= '0;
              st_r    <= S_READ;
            end else if (in_mode == ssl_pkg::MODE_PLACE && in_ok) begin
              place_r <= 1'b1;
              mot_r   <= in_motor;
              st_r    <= S_CALC;
            end
          end
        end
        S_READ: st_r <= S_CALC;
        S_CALC: begin
          if (place_r) begin
            st_r <= S_PWAIT;
          end else if (diff != '0) begin
            st_r <= S_PWAIT;
          end else if (last_m) begin
            st_r <= S_FIN;
          end else begin
            m_r   <= m_r + 1'b1;
            mot_r <= ssl_pkg::MOTOR_W'(m_r + 1'b1);
            st_r  <= S_READ;
          end
        end
        S_PWAIT: begin
          if (p_done) begin
            new_r.motor   <= mot_r;
            new_r.pulse   <= estop_r ? '0 : p_pulse;
            new_r.cmd     <= !estop_r;
            new_r.settled <= 1'b0;
            st_r          <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_r      <= pend_r;
              out_last_r <= 1'b0;
            end
            pend_r   <= new_r;
            pend_v_r <= 1'b1;
            if (place_r || last_m) begin
              st_r <= S_FIN;
            end else begin
              m_r   <= m_r + 1'b1;
              mot_r <= ssl_pkg::MOTOR_W'(m_r + 1'b1);
              st_r  <= S_READ;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (pend_v_r) begin
              out_r <= pend_r;
            end else begin
              out_r.motor   <= '0;
              out_r.pulse   <= '0;
              out_r.cmd     <= 1'b0;
              out_r.settled <= 1'b1;
            end
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            st_r       <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_v_r;
  assign out_motor         = out_r.motor;
  assign out_pulse_us      = out_r.pulse;
  assign out_command_valid = out_r.cmd;
  assign out_all_settled   = out_r.settled;
  assign out_last          = out_last_r;
endmodule

### verif/testbench.sv
// Testbench for the servo slew limiter: directed table plus random words, checked by a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int NMOT = 6;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  motor;
    logic [11:0] pulse;
    logic        cmd;
    logic        settled;
    logic        last;
  } servo_cmd_t;

  typedef struct {
    logic [1:0]        mode;
    logic [2:0]        motor;
    logic signed [8:0] angle;
    logic              estop;
    logic              chk;      // typed expectation present
    logic [11:0]       pulse;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_mode = '0;
  logic [2:0] in_motor = '0;
  logic signed [8:0] in_angle = '0;
  logic in_emergency_stop = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] out_motor;
  logic [11:0] out_pulse_us;
  logic out_command_valid, out_all_settled, out_last;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always #5 clk = ~clk;

  servo_slew_limiter_pulse_mapper_core u_dut (.*);

  // predictor state
  logic [7:0]        step_sh;
  logic [59:0]       lim_sh[NMOT];
  logic signed [8:0] tgt_sh[NMOT];
  logic signed [8:0] cur_sh[NMOT];
  servo_cmd_t pending_cmds[$];
  int mismatches = 0;
  int idle_pct = 26;

  function automatic int sx9(logic [8:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clamp_lim(int a, logic [59:0] lw);
    int lo, hi;
    lo = sx9(lw[8:0]);
    hi = sx9(lw[17:9]);
    if (a < lo) a = lo;
    if (a > hi) a = hi;
    return a;
  endfunction

  function automatic logic [11:0] map_pulse(int ang, logic [59:0] lw);
    longint a, amin, amax, pmin, pmax, span, num, n, d, q, p;
    a = longint'(clamp_lim(ang, lw));
    amin = longint'(sx9(lw[26:18]));
    amax = longint'(sx9(lw[35:27]));
    pmin = longint'(lw[47:36]);
    pmax = longint'(lw[59:48]);
    span = amax - amin;
    if (span == 0) return pmin[11:0];
    num = (pmax - pmin) * (a - amin);
    if (span < 0) begin
      span = -span;
      num = -num;
    end
    n = 2 * num + span;
    d = 2 * span;
    q = n / d;
    if (n % d != 0 && n < 0) q = q - 1;
    p = pmin + q;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p[11:0];
  endfunction

  function automatic void push_cmd(int m, logic [11:0] pl, logic cmd, logic st);
    servo_cmd_t c;
    c.motor = m[2:0];
    c.pulse = cmd ? pl : 12'd0;
    c.cmd = cmd;
    c.settled = st;
    c.last = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  // returns number of results predicted
  function automatic int predict_word(logic [1:0] mode, logic [2:0] mot,
                                      logic signed [8:0] ang, logic estop);
    int n, step, tg, df, dl;
    n = 0;
    if (mode == ssl_pkg::MODE_SET || mode == ssl_pkg::MODE_PLACE) begin
      if (mot >= NMOT) return 0;
      tgt_sh[mot] = ang;
      if (mode == ssl_pkg::MODE_SET) return 0;
      cur_sh[mot] = ang;
      push_cmd(int'(mot), map_pulse(int'(ang), lim_sh[mot]), !estop, 1'b0);
      pending_cmds[$].last = 1'b1;
      return 1;
    end
    if (mode != ssl_pkg::MODE_TICK) return 0;
    step = (step_sh == 0) ? 1 : int'(step_sh);
    for (int m = 0; m < NMOT; m++) begin
      tg = clamp_lim(int'(tgt_sh[m]), lim_sh[m]);
      df = tg - int'(cur_sh[m]);
      if (df == 0) continue;
      dl = (df > step) ? step : (df < -step) ? -step : df;
      cur_sh[m] = 9'(int'(cur_sh[m]) + dl);
      push_cmd(m, map_pulse(int'(cur_sh[m]), lim_sh[m]), !estop, 1'b0);
      n++;
    end
    if (n == 0) begin
      push_cmd(0, 12'd0, 1'b0, 1'b1);
      n = 1;
    end
    pending_cmds[$].last = 1'b1;
    return n;
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == ssl_pkg::REG_STEP) step_sh = val[7:0];
    else if (idx <= NMOT) lim_sh[idx-1] = val[59:0];
  endtask

  // valid stays up after a handshake until the next idle cycle or a new word
  task automatic send_word(logic [1:0] mode, logic [2:0] mot, logic signed [8:0] ang,
                           logic estop);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_mode <= mode;
    in_motor <= mot;
    in_angle <= ang;
    in_emergency_stop <= estop;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    void'(predict_word(mode, mot, ang, estop));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic logic [59:0] pack_lim(int lmin, int lmax, int amin, int amax,
                                           int pmin, int pmax);
    logic [8:0] a, b, c, d;
    logic [11:0] e, f;
    a = 9'(lmin); b = 9'(lmax); c = 9'(amin); d = 9'(amax);
    e = 12'(pmin); f = 12'(pmax);
    return {f, e, d, c, b, a};
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word motor=%0d pulse=%0d", out_motor,
                                       out_pulse_us);
      end else begin
        servo_cmd_t e;
        e = pending_cmds.pop_front();
        if (out_motor !== e.motor || out_pulse_us !== e.pulse ||
            out_command_valid !== e.cmd || out_all_settled !== e.settled ||
            out_last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp m=%0d p=%0d c=%b s=%b l=%b  got m=%0d p=%0d c=%b s=%b l=%b",
                     e.motor, e.pulse, e.cmd, e.settled, e.last, out_motor,
                     out_pulse_us, out_command_valid, out_all_settled, out_last);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    logic [59:0] lw;
    int kind;
    step_sh = ssl_pkg::STEP_RESET;
    for (int m = 0; m < NMOT; m++) begin
      lim_sh[m] = ssl_pkg::LIMITS_RESET;
      tgt_sh[m] = 0;
      cur_sh[m] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: {mode, motor, angle, estop, chk, pulse}
    rows = '{
      '{ssl_pkg::MODE_TICK,  0, 0,    0, 1, 0},     // all settled after reset
      '{ssl_pkg::MODE_PLACE, 0, 0,    0, 1, 500},
      '{ssl_pkg::MODE_PLACE, 1, 180,  0, 1, 2500},
      '{ssl_pkg::MODE_PLACE, 2, 90,   0, 1, 1500},
      '{ssl_pkg::MODE_PLACE, 3, -256, 0, 1, 500},   // clamps low
      '{ssl_pkg::MODE_PLACE, 4, 255,  0, 1, 2500},  // clamps high
      '{ssl_pkg::MODE_PLACE, 5, 45,   1, 1, 0},     // emergency stop
      '{ssl_pkg::MODE_SET,   0, 10,   0, 0, 0},
      '{ssl_pkg::MODE_SET,   1, -5,   0, 0, 0},
      '{ssl_pkg::MODE_TICK,  0, 0,    0, 0, 0},
      '{ssl_pkg::MODE_TICK,  0, 0,    1, 0, 0},
      '{MODE_UNUSED,         2, 77,   0, 0, 0},     // unused mode
      '{ssl_pkg::MODE_SET,   6, 33,   0, 0, 0},     // motor out of range
      '{ssl_pkg::MODE_PLACE, 7, 33,   0, 0, 0},
      '{ssl_pkg::MODE_TICK,  0, 0,    0, 0, 0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_word(r.mode, r.motor, r.angle, r.estop);
      if (r.chk && pending_cmds.size() != 0 && pending_cmds[$].pulse !== r.pulse) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: predictor %0d vs %0d", i,
                                       pending_cmds[$].pulse, r.pulse);
      end
    end
    drain();

    // extreme and corner calibrations
    cfg_write(ssl_pkg::REG_STEP, 64'd0);
    cfg_write(3'd1, pack_lim(20, -20, 0, 0, 1234, 99));          // crossed, zero span
    cfg_write(3'd2, pack_lim(-256, 255, 100, -100, 4095, 0));    // negative span
    cfg_write(3'd3, pack_lim(-256, 255, -256, 255, 0, 4095));
    cfg_write(3'd4, pack_lim(-90, 90, 0, 1, 0, 4095));           // saturates
    cfg_write(3'd5, {4'hf, 60'h0});
    cfg_write(3'd6, 64'hffff_ffff_ffff_ffff);
    cfg_write(3'd7, 64'h1234);                                   // ignored index
    for (int i = 0; i < 12; i++) send_word(ssl_pkg::MODE_TICK, 3'd0, 9'sd0, 1'b0);
    for (int m = 0; m < NMOT; m++) send_word(ssl_pkg::MODE_SET, 3'(m), 9'(255), m[0]);
    for (int i = 0; i < 6; i++) send_word(ssl_pkg::MODE_TICK, 3'd0, 9'sd0, i[0]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      cfg_write(ssl_pkg::REG_STEP,
                64'(phase == 0 ? 180 : phase == 1 ? 1 : $urandom_range(255)));
      for (int m = 1; m <= NMOT; m++) begin
        lw = 60'({$urandom, $urandom});
        if ($urandom_range(3) != 0)
          lw = pack_lim($urandom_range(90) - 120, $urandom_range(120) + 60,
                        $urandom_range(60) - 60, $urandom_range(200),
                        $urandom_range(1000), $urandom_range(3000) + 1000);
        cfg_write(3'(m), {4'h0, lw});
      end
      idle_pct = (phase == 2) ? 0 : 26;
      for (int i = 0; i < 115; i++) begin
        kind = $urandom_range(99);
        if (kind < 40)
          send_word(ssl_pkg::MODE_SET, 3'($urandom_range(5)), 9'($urandom),
                    $urandom_range(19) == 0);
        else if (kind < 80)
          send_word(ssl_pkg::MODE_TICK, 3'($urandom), 9'($urandom),
                    $urandom_range(9) == 0);
        else if (kind < 94)
          send_word(ssl_pkg::MODE_PLACE, 3'($urandom_range(5)), 9'($urandom),
                    $urandom_range(9) == 0);
        else
          send_word(2'($urandom), 3'($urandom), 9'($urandom), 1'($urandom));
        if (i == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_cmds.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    idle_pct = 26;

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

### filelist.f
rtl/core/ssl_pkg.sv
rtl/core/ssl_div.sv
rtl/core/ssl_pulse.sv
rtl/core/servo_slew_limiter_pulse_mapper_core.sv
verif/testbench.sv
